### sv/mouse_packet_cursor_tracker_defines.svh
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker_defines
// assertion macros shared by the cursor tracker rtl
// ----------------------------------------------------------------------------
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define MPCT_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also runs while reset is held
`define MPCT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define MPCT_ASSERT_CLK(lbl, prop, msg)

`define MPCT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

### sv/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// types and fixed constants of the mouse packet cursor tracker
// ----------------------------------------------------------------------------
package mpct_pkg;

    // fixed field widths
    localparam int BYTE_BITS    = 8;
    localparam int BOUND_BITS   = 13;
    localparam int OUT_POS_BITS = 12;
    localparam int CFG_IDX_BITS = 2;

    // bit positions in the packet header byte
    localparam int LEFT_IDX   = 0;
    localparam int RIGHT_IDX  = 1;
    localparam int SYNC_IDX   = 3;
    localparam int X_SIGN_IDX = 4;
    localparam int Y_SIGN_IDX = 5;
    localparam logic [BYTE_BITS-1:0] OVERFLOW_MASK = 8'hC0;

    // reset values
    localparam logic [BOUND_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [BOUND_BITS-1:0] HEIGHT_RESET = 13'd768;
    localparam int unsigned POS_X_RESET = 512;
    localparam int unsigned POS_Y_RESET = 384;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH_BOUND  = 2'd0,
        REG_HEIGHT_BOUND = 2'd1
    } t_cfg_reg;

    // byte position within a packet
    typedef enum logic [2:0] {
        PH_HEAD   = 3'b001,
        PH_XDELTA = 3'b010,
        PH_YDELTA = 3'b100
    } t_phase;

    // one result word
    typedef struct packed {
        logic [OUT_POS_BITS-1:0] cursor_x;
        logic [OUT_POS_BITS-1:0] cursor_y;
        logic                    left_pressed;
        logic                    right_pressed;
        logic                    movement_dropped;
    } t_result;

endpackage

### sv/mpct_ifs.sv
// ----------------------------------------------------------------------------
// mpct_ifs
// valid/ready channels of the cursor tracker: byte in, result out, config
// ----------------------------------------------------------------------------

// controller byte channel
interface mpct_in_if
    import mpct_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 from_aux;
    logic [BYTE_BITS-1:0] data_byte;

    modport source (output valid, from_aux, data_byte, input ready);
    modport sink   (input valid, from_aux, data_byte, output ready);
endinterface

// cursor result channel
interface mpct_out_if
    import mpct_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic [OUT_POS_BITS-1:0] cursor_x;
    logic [OUT_POS_BITS-1:0] cursor_y;
    logic                    left_pressed;
    logic                    right_pressed;
    logic                    movement_dropped;

    modport source (output valid, cursor_x, cursor_y, left_pressed, right_pressed,
                    movement_dropped, input ready);
    modport sink   (input valid, cursor_x, cursor_y, left_pressed, right_pressed,
                    movement_dropped, output ready);
endinterface

// configuration write channel
interface mpct_cfg_if
    import mpct_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [BOUND_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/mpct_step.sv
// ----------------------------------------------------------------------------
// mpct_step
// next state and result for one mouse byte: packet assembly, delta, clamp
// ----------------------------------------------------------------------------
module mpct_step
    import mpct_pkg::*;
#(
    parameter int POSITION_BITS = 12
) (
    input  t_phase                   i_phase,
    input  logic [BYTE_BITS-1:0]     i_header,
    input  logic [BYTE_BITS-1:0]     i_xbyte,
    input  logic [POSITION_BITS-1:0] i_pos_x,
    input  logic [POSITION_BITS-1:0] i_pos_y,
    input  logic [BOUND_BITS-1:0]    i_width_bound,
    input  logic [BOUND_BITS-1:0]    i_height_bound,
    input  logic [BYTE_BITS-1:0]     i_data_byte,
    output t_phase                   o_phase,
    output logic [BYTE_BITS-1:0]     o_header,
    output logic [BYTE_BITS-1:0]     o_xbyte,
    output logic [POSITION_BITS-1:0] o_pos_x,
    output logic [POSITION_BITS-1:0] o_pos_y,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    localparam int P  = POSITION_BITS;
    localparam int BW = (P + 1 > BOUND_BITS) ? P + 1 : BOUND_BITS;
    localparam logic [BW-1:0] LIMIT = BW'(1) << P;

    // clamp a signed sum to 0..bound-1, bound taken as at least 1 and at most 2^P
    function automatic logic [P-1:0] clamp_pos(input logic signed [P+1:0] v,
                                               input logic [BOUND_BITS-1:0] bound);
        logic [BW-1:0] b;
        logic [P-1:0]  top;
        b = BW'(bound);
        if (b == '0) begin
            b = BW'(1);
        end
        if (b > LIMIT) begin
            b = LIMIT;
        end
        top = P'(b - BW'(1));
        if (v < 0) begin
            return '0;
        end else if (v > $signed({2'b00, top})) begin
            return top;
        end else begin
            return v[P-1:0];
        end
    endfunction

    logic                   x_sign;
    logic                   y_sign;
    logic                   dropped;
    logic signed [P+1:0]    sum_x;
    logic signed [P+1:0]    sum_y;

    // nine-bit deltas are {sign, byte}; y counts upward so it is subtracted
    assign x_sign  = i_header[X_SIGN_IDX];
    assign y_sign  = i_header[Y_SIGN_IDX];
    assign dropped = |(i_header & OVERFLOW_MASK);
    assign sum_x   = $signed({2'b00, i_pos_x}) + $signed({{(P-6){x_sign}}, i_xbyte});
    assign sum_y   = $signed({2'b00, i_pos_y}) - $signed({{(P-6){y_sign}}, i_data_byte});

    // packet assembly
    always_comb begin
        o_phase     = i_phase;
        o_header    = i_header;
        o_xbyte     = i_xbyte;
        o_pos_x     = i_pos_x;
        o_pos_y     = i_pos_y;
        o_res_valid = 1'b0;
        unique case (i_phase)
            PH_XDELTA: begin
                o_xbyte = i_data_byte;
                o_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                o_phase     = PH_HEAD;
                o_res_valid = 1'b1;
                if (!dropped) begin
                    o_pos_x = clamp_pos(sum_x, i_width_bound);
                    o_pos_y = clamp_pos(sum_y, i_height_bound);
                end
            end
            default: begin
                // resync: only a byte with the sync bit opens a packet
                if (i_data_byte[SYNC_IDX]) begin
                    o_header = i_data_byte;
                    o_phase  = PH_XDELTA;
                end else begin
                    o_phase  = PH_HEAD;
                end
            end
        endcase
    end

    // result word
    assign o_res.cursor_x         = OUT_POS_BITS'(o_pos_x);
    assign o_res.cursor_y         = OUT_POS_BITS'(o_pos_y);
    assign o_res.left_pressed     = i_header[LEFT_IDX];
    assign o_res.right_pressed    = i_header[RIGHT_IDX];
    assign o_res.movement_dropped = dropped;

endmodule

### sv/mpct_skid.sv
// ----------------------------------------------------------------------------
// mpct_skid
// output register with one skid entry, so a stalled result does not stop input
// ----------------------------------------------------------------------------
module mpct_skid
    import mpct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_o_valid;
    logic    r_s_valid;
    t_result r_o_data;
    t_result r_s_data;
    logic    pop;

    assign pop     = r_o_valid && i_ready;
    assign o_full  = r_s_valid;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (pop || !r_o_valid) begin
            r_o_valid <= r_s_valid || i_push;
            r_s_valid <= r_s_valid && i_push;
        end else if (i_push) begin
            r_s_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop || !r_o_valid) begin
            if (r_s_valid) begin
                r_o_data <= r_s_data;
                r_s_data <= i_data;
            end else begin
                r_o_data <= i_data;
            end
        end else if (i_push) begin
            r_s_data <= i_data;
        end
    end

endmodule

### sv/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker: three-byte mouse packets to clamped cursor
// each result is registered; a stalled o_out keeps it in the skid entry
// throughput: one byte per cycle; input stalls only with two results unread
// reset: synchronous, bounds 1024 x 768, cursor 512,384, awaiting a header
// ----------------------------------------------------------------------------
`include "mouse_packet_cursor_tracker_defines.svh"

module mouse_packet_cursor_tracker
    import mpct_pkg::*;
#(
    parameter int POSITION_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpct_in_if.sink   i_in,
    mpct_out_if.source o_out,
    mpct_cfg_if.sink  i_cfg
);

    localparam int P = POSITION_BITS;

    t_phase                r_phase;
    logic [BYTE_BITS-1:0]  r_header;
    logic [BYTE_BITS-1:0]  r_xbyte;
    logic [P-1:0]          r_pos_x;
    logic [P-1:0]          r_pos_y;
    logic [BOUND_BITS-1:0] r_width_bound;
    logic [BOUND_BITS-1:0] r_height_bound;

    t_phase                n_phase;
    logic [BYTE_BITS-1:0]  n_header;
    logic [BYTE_BITS-1:0]  n_xbyte;
    logic [P-1:0]          n_pos_x;
    logic [P-1:0]          n_pos_y;

    logic    step_res_valid;
    t_result step_res;
    t_result out_res;
    logic    skid_full;
    logic    take;
    logic    push;

    // a mouse byte accepted this cycle
    assign i_in.ready = !skid_full;
    assign take       = i_in.valid && i_in.ready && i_in.from_aux;
    assign push       = take && step_res_valid;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_bound  <= WIDTH_RESET;
            r_height_bound <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_WIDTH_BOUND:  r_width_bound  <= i_cfg.data;
                REG_HEIGHT_BOUND: r_height_bound <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // packet decode and cursor update
    mpct_step #(
        .POSITION_BITS (P)
    ) u_step (
        .i_phase        (r_phase),
        .i_header       (r_header),
        .i_xbyte        (r_xbyte),
        .i_pos_x        (r_pos_x),
        .i_pos_y        (r_pos_y),
        .i_width_bound  (r_width_bound),
        .i_height_bound (r_height_bound),
        .i_data_byte    (i_in.data_byte),
        .o_phase        (n_phase),
        .o_header       (n_header),
        .o_xbyte        (n_xbyte),
        .o_pos_x        (n_pos_x),
        .o_pos_y        (n_pos_y),
        .o_res_valid    (step_res_valid),
        .o_res          (step_res)
    );

    // packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_header <= '0;
            r_xbyte  <= '0;
            r_pos_x  <= P'(POS_X_RESET);
            r_pos_y  <= P'(POS_Y_RESET);
        end else if (take) begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_xbyte  <= n_xbyte;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
        end
    end

    // result register and skid entry
    mpct_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (step_res),
        .o_full  (skid_full),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_res)
    );

    assign o_out.cursor_x         = out_res.cursor_x;
    assign o_out.cursor_y         = out_res.cursor_y;
    assign o_out.left_pressed     = out_res.left_pressed;
    assign o_out.right_pressed    = out_res.right_pressed;
    assign o_out.movement_dropped = out_res.movement_dropped;

    // checks
    `MPCT_ASSERT_CLK(a_push_ends_packet, push |=> (r_phase == PH_HEAD), "packet not closed after result")
    `MPCT_ASSERT_CLK(a_stall_only_full, !i_in.ready |-> (skid_full && o_out.valid), "input stalled with room")
    `MPCT_ASSERT_CLK(a_result_on_third, push |-> (r_phase == PH_YDELTA), "result outside third byte")
    `MPCT_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_phase == PH_HEAD && !o_out.valid), "reset state wrong")

endmodule
